/* rtl/core/metw_pkg.sv */
package metw_pkg;

  localparam int HISTORY_DEPTH = 1024;
  localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
  localparam int TIME_W        = 32;
  localparam int INDEX_W       = 32;
  localparam int OUT_CNT_W     = 11;
  localparam int WINDOW_RESET  = 60;
  localparam int OUT_DATA_W    = 152;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [INDEX_W-1:0] first_index;
    logic [TIME_W-1:0]  first_time;
    logic [INDEX_W-1:0] last_index;
    logic [TIME_W-1:0]  last_time;
  } walk_result_t;

endpackage

/* rtl/core/metw_ram.sv */
module metw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/metw_walk.sv */
module metw_walk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [metw_pkg::TIME_W-1:0]   window,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [metw_pkg::TIME_W-1:0]   in_time,
  output logic                          res_valid,
  input  logic                          res_take,
  output metw_pkg::walk_result_t        res
);

  typedef enum logic [1:0] {IDLE, WALK, DONE} state_t;

  state_t                         state;
  logic [metw_pkg::INDEX_W-1:0]   event_index;
  logic [metw_pkg::ADDR_W-1:0]    wr_ptr;
  logic [metw_pkg::ADDR_W-1:0]    rd_ptr;
  logic [metw_pkg::INDEX_W-1:0]   rd_index;
  logic [metw_pkg::ADDR_W-1:0]    issued;
  logic [metw_pkg::ADDR_W-1:0]    limit;
  logic                           pend;
  logic [metw_pkg::TIME_W-1:0]    now;

  logic                           accept;
  logic [metw_pkg::ADDR_W-1:0]    wr_ptr_next;
  logic [metw_pkg::ADDR_W-1:0]    rd_addr;
  logic [metw_pkg::TIME_W-1:0]    rd_data;
  logic                           rd_en;
  logic                           in_window;
  logic                           pass;
  logic                           fail;
  logic                           can_issue;

  localparam logic [metw_pkg::ADDR_W-1:0] LAST_SLOT =
    metw_pkg::ADDR_W'(metw_pkg::HISTORY_DEPTH - 1);

  assign in_ready    = (state == IDLE);
  assign accept      = in_valid && in_ready;
  assign res_valid   = (state == DONE);
  assign wr_ptr_next = (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
  assign rd_addr     = (rd_ptr == '0) ? LAST_SLOT : rd_ptr - 1'b1;

  // stored time later than now, or further back than the window, ends the walk
  assign in_window = (now >= rd_data) && ((now - rd_data) <= window);
  assign pass      = (state == WALK) && pend && in_window;
  assign fail      = (state == WALK) && pend && !in_window;
  assign can_issue = issued < limit;
  assign rd_en     = (state == WALK) && !fail && can_issue;

  metw_ram #(
    .WIDTH(metw_pkg::TIME_W),
    .DEPTH(metw_pkg::HISTORY_DEPTH)
  ) u_history (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wr_ptr),
    .wr_data (in_time),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      event_index <= '0;
      wr_ptr      <= '0;
      pend        <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            now             <= in_time;
            rd_ptr          <= wr_ptr;
            rd_index        <= event_index;
            issued          <= '0;
            pend            <= 1'b0;
            limit           <= (event_index < metw_pkg::INDEX_W'(metw_pkg::HISTORY_DEPTH - 1))
                               ? metw_pkg::ADDR_W'(event_index) : LAST_SLOT;
            res.count       <= metw_pkg::CNT_W'(1);
            res.first_index <= event_index;
            res.first_time  <= in_time;
            res.last_index  <= event_index;
            res.last_time   <= in_time;
            event_index     <= event_index + 1'b1;
            wr_ptr          <= wr_ptr_next;
            state           <= WALK;
          end
        end
        WALK: begin
          if (pass) begin
            res.count       <= res.count + 1'b1;
            res.first_index <= rd_index;
            res.first_time  <= rd_data;
          end
          if (rd_en) begin
            rd_ptr   <= rd_addr;
            rd_index <= rd_index - 1'b1;
            issued   <= issued + 1'b1;
          end
          pend <= rd_en;
          if (!rd_en) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (res_take) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/max_events_in_time_window.sv */
// channel        | direction | fields (lsb first)
// s_axis         | in        | tdata: event_time[31:0]
// m_axis         | out       | tdata: current_count, best_count, best_first_index,
//                |           |        best_last_index, best_first_time, best_last_time
// cfg_wr_*       | in        | window_seconds, written when cfg_wr_en is high
//
// each event is followed by a walk that reads n earlier entries back from the history ram
// (one per cycle, at most the current count, capped at the depth less one), and the next event
// is taken only after the result of that walk has moved to the result register
// reset is synchronous; window_seconds returns to 60, indices and best window clear
// the result register lets the next event enter while a result waits for m_axis_tready
module max_events_in_time_window (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // event_time[31:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // current_count[10:0], best_count[21:11], best_first_index[53:22],
  // best_last_index[85:54], best_first_time[117:86], best_last_time[149:118]
  output logic [metw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic [metw_pkg::TIME_W-1:0]  window;
  logic                         res_valid;
  logic                         res_take;
  metw_pkg::walk_result_t       res;

  logic [metw_pkg::CNT_W-1:0]   top_count;
  logic [metw_pkg::INDEX_W-1:0] top_first_index;
  logic [metw_pkg::INDEX_W-1:0] top_last_index;
  logic [metw_pkg::TIME_W-1:0]  top_first_time;
  logic [metw_pkg::TIME_W-1:0]  top_last_time;
  logic [metw_pkg::CNT_W-1:0]   cur_count;
  logic                         better;

  metw_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .window    (window),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_time   (s_axis_tdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  assign res_take = res_valid && (!m_axis_tvalid || m_axis_tready);
  assign better   = res.count > top_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      window          <= metw_pkg::TIME_W'(metw_pkg::WINDOW_RESET);
      m_axis_tvalid   <= 1'b0;
      top_count       <= '0;
      top_first_index <= '0;
      top_last_index  <= '0;
      top_first_time  <= '0;
      top_last_time   <= '0;
    end else begin
      if (cfg_wr_en) begin
        window <= cfg_wr_data;
      end
      if (res_take) begin
        m_axis_tvalid <= 1'b1;
        cur_count     <= res.count;
        if (better) begin
          top_count       <= res.count;
          top_first_index <= res.first_index;
          top_last_index  <= res.last_index;
          top_first_time  <= res.first_time;
          top_last_time   <= res.last_time;
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {
    2'b00,
    top_last_time,
    top_first_time,
    top_last_index,
    top_first_index,
    metw_pkg::OUT_CNT_W'(top_count),
    metw_pkg::OUT_CNT_W'(cur_count)
  };

endmodule
